/* hdl/frame_address_and_duplicate_filter_top_defines.svh */
// Assertion macros for the checker file of the frame filter.
`ifndef FRAME_ADDRESS_AND_DUPLICATE_FILTER_TOP_DEFINES_SVH
`define FRAME_ADDRESS_AND_DUPLICATE_FILTER_TOP_DEFINES_SVH

// Clocked property, masked while reset is asserted.
`define FADF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define FADF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/fadf_pkg.sv */
// Shared types and constants of the frame address and duplicate filter.
package fadf_pkg;

    localparam int TABLE_SLOTS = 8;
    localparam int HEAD_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    localparam int ID_W       = 8;
    localparam int SEQ_W      = 8;
    localparam int TYPE_W     = 8;
    localparam int COUNT_W    = 16;
    localparam int VERDICT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [ID_W-1:0]    BROADCAST_RESET = 8'd255;
    localparam logic [COUNT_W-1:0] QUIET_RESET     = 16'd100;

    localparam logic OP_TICK = 1'b1;

    typedef enum logic [VERDICT_W-1:0] {
        V_ACCEPTED  = 3'd0,
        V_BAD_CRC   = 3'd1,
        V_NOT_ADDR  = 3'd2,
        V_DUPLICATE = 3'd3,
        V_DISABLED  = 3'd4,
        V_TICK      = 3'd5
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED      = 2'd0,
        CFG_OWN_ID       = 2'd1,
        CFG_BROADCAST_ID = 2'd2,
        CFG_QUIET_TICKS  = 2'd3
    } cfg_idx_t;

    // Class assigned by the front end; the back end acts on it.
    typedef enum logic [2:0] {
        K_DISABLED,
        K_BAD_CRC,
        K_NOT_ADDR,
        K_CANDIDATE,
        K_TICK_HELD,
        K_TICK
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              self_sent;
        logic [ID_W-1:0]   sender_id;
        logic [SEQ_W-1:0]  seq_num;
        logic [TYPE_W-1:0] msg_type;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]    broadcast_id;
        logic [COUNT_W-1:0] quiet_ticks;
    } back_cfg_t;

endpackage

/* hdl/fadf_front.sv */
// Front end: configuration registers, item acceptance and classification.
module fadf_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             queue_full,
    input  logic                             opcode,
    input  logic                             crc_ok,
    input  logic [fadf_pkg::ID_W-1:0]        sender_id,
    input  logic [fadf_pkg::ID_W-1:0]        dest_id,
    input  logic [fadf_pkg::SEQ_W-1:0]       seq_num,
    input  logic [fadf_pkg::TYPE_W-1:0]      msg_type,
    input  logic                             cfg_valid,
    input  logic [fadf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fadf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             cfg_ready,
    output logic                             busy,
    output logic                             push,
    output fadf_pkg::item_t                  item,
    output fadf_pkg::back_cfg_t              back_cfg
);
    import fadf_pkg::*;

    logic               enabled_reg;
    logic [ID_W-1:0]    own_id_reg;
    logic [ID_W-1:0]    broadcast_id_reg;
    logic [COUNT_W-1:0] quiet_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg      <= 1'b0;
            own_id_reg       <= '0;
            broadcast_id_reg <= BROADCAST_RESET;
            quiet_ticks_reg  <= QUIET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENABLED:      enabled_reg      <= cfg_data[0];
                CFG_OWN_ID:       own_id_reg       <= cfg_data[ID_W-1:0];
                CFG_BROADCAST_ID: broadcast_id_reg <= cfg_data[ID_W-1:0];
                CFG_QUIET_TICKS:  quiet_ticks_reg  <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign busy = queue_full;
    assign push = start && !queue_full;

    always_comb
    begin
        item.sender_id = sender_id;
        item.seq_num   = seq_num;
        item.msg_type  = msg_type;
        item.self_sent = enabled_reg && (opcode != OP_TICK) && crc_ok
                         && (sender_id == own_id_reg);
        if (opcode == OP_TICK)
            item.kind = enabled_reg ? K_TICK : K_TICK_HELD;
        else if (!enabled_reg)
            item.kind = K_DISABLED;
        else if (!crc_ok)
            item.kind = K_BAD_CRC;
        else if ((dest_id != broadcast_id_reg) && (dest_id != own_id_reg))
            item.kind = K_NOT_ADDR;
        else
            item.kind = K_CANDIDATE;
    end

    assign back_cfg.broadcast_id = broadcast_id_reg;
    assign back_cfg.quiet_ticks  = quiet_ticks_reg;

endmodule

/* hdl/fadf_queue.sv */
// Short queue of classified items between front and back end.
module fadf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fadf_pkg::item_t item_in,
    input  logic            pop,
    output fadf_pkg::item_t item_out,
    output logic            empty,
    output logic            full
);
    import fadf_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign item_out = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= item_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* hdl/fadf_back.sv */
// Back end: duplicate table, ring head, silence timer and result register.
module fadf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  fadf_pkg::item_t               item,
    input  fadf_pkg::back_cfg_t           back_cfg,
    output logic                          pop,
    output logic                          done,
    output logic [fadf_pkg::VERDICT_W-1:0] verdict,
    output logic                          self_sent,
    output logic [fadf_pkg::TYPE_W-1:0]   accepted_type,
    output logic                          table_cleared
);
    import fadf_pkg::*;

    logic [ID_W-1:0]    slot_sender_reg [TABLE_SLOTS];
    logic [SEQ_W-1:0]   slot_seq_reg    [TABLE_SLOTS];
    logic [HEAD_W-1:0]  head_reg;
    logic [HEAD_W-1:0]  head_next;
    logic [COUNT_W-1:0] quiet_count_reg;
    logic [COUNT_W-1:0] quiet_count_next;
    logic               quiet_armed_reg;
    logic [COUNT_W-1:0] limit;
    logic               expire;
    logic [TABLE_SLOTS-1:0] hit;
    logic               dup;
    logic               write_slot;

    verdict_t           verdict_reg;
    logic               done_reg;
    logic               self_reg;
    logic [TYPE_W-1:0]  type_reg;
    logic               cleared_reg;

    assign pop = item_valid;

    // Parallel match against occupied slots.
    always_comb
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            hit[i] = (slot_sender_reg[i] != back_cfg.broadcast_id)
                     && (slot_sender_reg[i] == item.sender_id)
                     && (slot_seq_reg[i] == item.seq_num);
        end
    end

    assign dup        = |hit;
    assign write_slot = item_valid && (item.kind == K_CANDIDATE) && !dup;
    assign head_next  = (head_reg == HEAD_W'(TABLE_SLOTS - 1)) ? '0 : head_reg + 1'b1;

    // Saturating silence count; a limit of zero acts as one.
    assign quiet_count_next = (quiet_count_reg == '1) ? quiet_count_reg
                                                       : quiet_count_reg + 1'b1;
    assign limit  = (back_cfg.quiet_ticks == '0) ? COUNT_W'(1) : back_cfg.quiet_ticks;
    assign expire = (quiet_count_next >= limit);

    // Sequence numbers carry no reset.
    always_ff @(posedge clk)
    begin
        if (write_slot)
            slot_seq_reg[head_reg] <= item.seq_num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
                slot_sender_reg[i] <= BROADCAST_RESET;
            head_reg        <= '0;
            quiet_count_reg <= '0;
            quiet_armed_reg <= 1'b0;
            done_reg        <= 1'b0;
            verdict_reg     <= V_ACCEPTED;
            self_reg        <= 1'b0;
            type_reg        <= '0;
            cleared_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= item_valid;
            if (item_valid)
            begin
                self_reg    <= item.self_sent;
                type_reg    <= '0;
                cleared_reg <= 1'b0;
                case (item.kind)
                    K_DISABLED:
                    begin
                        verdict_reg <= V_DISABLED;
                    end
                    K_BAD_CRC:
                    begin
                        verdict_reg     <= V_BAD_CRC;
                        quiet_count_reg <= '0;
                        quiet_armed_reg <= 1'b1;
                    end
                    K_NOT_ADDR:
                    begin
                        verdict_reg     <= V_NOT_ADDR;
                        quiet_count_reg <= '0;
                        quiet_armed_reg <= 1'b1;
                    end
                    K_CANDIDATE:
                    begin
                        quiet_count_reg <= '0;
                        quiet_armed_reg <= 1'b1;
                        if (dup)
                            verdict_reg <= V_DUPLICATE;
                        else
                        begin
                            verdict_reg               <= V_ACCEPTED;
                            type_reg                  <= item.msg_type;
                            slot_sender_reg[head_reg] <= item.sender_id;
                            head_reg                  <= head_next;
                        end
                    end
                    K_TICK:
                    begin
                        verdict_reg <= V_TICK;
                        if (quiet_armed_reg)
                        begin
                            if (expire)
                            begin
                                for (int i = 0; i < TABLE_SLOTS; i++)
                                    slot_sender_reg[i] <= back_cfg.broadcast_id;
                                quiet_count_reg <= '0;
                                quiet_armed_reg <= 1'b0;
                                cleared_reg     <= 1'b1;
                            end
                            else
                                quiet_count_reg <= quiet_count_next;
                        end
                    end
                    K_TICK_HELD:
                    begin
                        verdict_reg <= V_TICK;
                    end
                    default:
                    begin
                        verdict_reg <= V_TICK;
                    end
                endcase
            end
        end
    end

    assign done          = done_reg;
    assign verdict       = verdict_reg;
    assign self_sent     = self_reg;
    assign accepted_type = type_reg;
    assign table_cleared = cleared_reg;

endmodule

/* hdl/frame_address_and_duplicate_filter_top.sv */
// Top level of the frame address and duplicate filter.
//
// Every item (a frame header or a frame-time tick) is taken on a rising edge
// with start high and busy low, and yields exactly one result, shown for one
// cycle with done high; the result is registered in the back end. The
// receiver cannot stall: done is a strobe. One item can be taken per cycle
// while busy is low; the back end retires one queued item per cycle, so
// the two-entry queue never fills and busy stays low in normal use. The front
// end checks enable, CRC and addressing against the configuration registers;
// the back end owns the eight-slot duplicate ring, whose entries are compared
// in parallel, and the silence timer that empties the ring after quiet_ticks
// armed ticks. A result needs no acknowledge. Configuration writes are
// always ready and are to be issued only while no item is in flight.
module frame_address_and_duplicate_filter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // item channel
    input  logic                            start,
    output logic                            busy,
    input  logic                            opcode,
    input  logic                            crc_ok,
    input  logic [fadf_pkg::ID_W-1:0]       sender_id,
    input  logic [fadf_pkg::ID_W-1:0]       dest_id,
    input  logic [fadf_pkg::SEQ_W-1:0]      seq_num,
    input  logic [fadf_pkg::TYPE_W-1:0]     msg_type,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fadf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fadf_pkg::CFG_DATA_W-1:0] cfg_data,
    // result strobe and fields
    output logic                            done,
    output logic [fadf_pkg::VERDICT_W-1:0]  verdict,
    output logic                            self_sent,
    output logic [fadf_pkg::TYPE_W-1:0]     accepted_type,
    output logic                            table_cleared
);
    import fadf_pkg::*;

    logic      queue_full;
    logic      queue_empty;
    logic      push;
    logic      pop;
    item_t     front_item;
    item_t     back_item;
    back_cfg_t back_cfg;

    // Front: config registers and classification of each transfer.
    fadf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .queue_full (queue_full),
        .opcode     (opcode),
        .crc_ok     (crc_ok),
        .sender_id  (sender_id),
        .dest_id    (dest_id),
        .seq_num    (seq_num),
        .msg_type   (msg_type),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg_ready  (cfg_ready),
        .busy       (busy),
        .push       (push),
        .item       (front_item),
        .back_cfg   (back_cfg)
    );

    // Decoupling queue; keeps item order.
    fadf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .item_out (back_item),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    // Back: table lookup/update, silence timer, registered result.
    fadf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (!queue_empty),
        .item          (back_item),
        .back_cfg      (back_cfg),
        .pop           (pop),
        .done          (done),
        .verdict       (verdict),
        .self_sent     (self_sent),
        .accepted_type (accepted_type),
        .table_cleared (table_cleared)
    );

endmodule

/* hdl/fadf_checker.sv */
// Port-level checker for the frame filter, bound to the top level.
`include "frame_address_and_duplicate_filter_top_defines.svh"

module fadf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [fadf_pkg::VERDICT_W-1:0] verdict,
    input logic                           self_sent,
    input logic [fadf_pkg::TYPE_W-1:0]    accepted_type,
    input logic                           table_cleared
);
    import fadf_pkg::*;

    `FADF_ASSERT(a_result_latency, (start && !busy) |=> ##1 done, "missing result")
    `FADF_ASSERT(a_no_spurious, done |-> $past(start && !busy, 2), "result without item")
    `FADF_ASSERT(a_type_only_accepted, (done && (verdict != V_ACCEPTED)) |-> (accepted_type == '0), "type on rejected item")
    `FADF_ASSERT(a_clear_on_tick, (done && (table_cleared || self_sent)) |-> ((table_cleared && (verdict == V_TICK) && !self_sent) || (!table_cleared && (verdict == V_ACCEPTED || verdict == V_NOT_ADDR || verdict == V_DUPLICATE))), "flag on wrong verdict")
    `FADF_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> (!done && !busy), "activity in reset")

endmodule

bind frame_address_and_duplicate_filter_top fadf_checker u_fadf_checker (.*);
